FILE: hdl/rle8_bitmap_decoder_unit_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef RLE8_BITMAP_DECODER_UNIT_ASSERT_SVH
`define RLE8_BITMAP_DECODER_UNIT_ASSERT_SVH

// Implication checked on every rising edge of clk, suspended while rst_n is low.
`define RLE8_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, suspended while rst_n is low.
`define RLE8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rle8_pkg.sv
package rle8_pkg;

  // Request codes carried by in_req_type.
  localparam logic [1:0] REQ_FRAME_START = 2'd0;
  localparam logic [1:0] REQ_PALETTE_WR  = 2'd1;
  localparam logic [1:0] REQ_STREAM_BYTE = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // Escape codes that follow a zero count byte.
  localparam logic [7:0] ESC_END_OF_LINE   = 8'd0;
  localparam logic [7:0] ESC_END_OF_BITMAP = 8'd1;
  localparam logic [7:0] ESC_DELTA         = 8'd2;

  // Fixed field widths of the ports.
  localparam int unsigned OUT_COORD_W = 16;
  localparam int unsigned DIM_W       = 16;
  localparam int unsigned COLOR_W     = 24;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_INDEX   = 3'd1,
    PH_ESCAPE  = 3'd2,
    PH_DX      = 3'd3,
    PH_DY      = 3'd4,
    PH_LITERAL = 3'd5,
    PH_PAD     = 3'd6
  } phase_t;

endpackage

FILE: hdl/rle8_ram.sv
module rle8_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/rle8_bitmap_decoder_unit.sv
// Run items pass stage 1 and the output register to out_; throughput is 1 item per cycle
// while out_stall is low; the palette RAM is read once per run, written once per write.
// A stall on the out_ side backs up through one stage before in_stall rises.
// Reset (rst_n low, synchronous) clears the parser, the cursor, the pipeline valids and
// the palette valid bits, so every palette entry reads as zero until it is written.
`include "rle8_bitmap_decoder_unit_assert.svh"

module rle8_bitmap_decoder_unit #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned COORD_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  // Configuration write port. Always ready.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rle8_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rle8_pkg::DIM_W-1:0]      cfg_data,

  // Input item channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_palette_index,
  input  logic [7:0]  in_palette_blue,
  input  logic [7:0]  in_palette_green,
  input  logic [7:0]  in_palette_red,
  input  logic [7:0]  in_stream_byte,

  // Result item channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_run_x,
  output logic [15:0] out_run_y,
  output logic [7:0]  out_run_length,
  output logic [31:0] out_run_color,
  output logic        out_frame_end,
  output logic        out_outside
);

  localparam int unsigned AW    = $clog2(PALETTE_ENTRIES);
  localparam int unsigned YW    = COORD_BITS + 1;
  localparam int unsigned CMP_W = rle8_pkg::OUT_COORD_W + 1;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  // ---------------------------------------------------------------------------
  // Configuration registers. The port never pushes back; the user must write only
  // while the block is idle, and the block itself does not enforce it.
  // ---------------------------------------------------------------------------
  logic [rle8_pkg::DIM_W-1:0] image_width_r;
  logic [rle8_pkg::DIM_W-1:0] image_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= rle8_pkg::DIM_W'(1);
      image_height_r <= rle8_pkg::DIM_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rle8_pkg::CFG_IMAGE_WIDTH) begin
        image_width_r <= cfg_data;
      end
      if (cfg_index == rle8_pkg::CFG_IMAGE_HEIGHT) begin
        image_height_r <= cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage 1 holds a run while its palette read is in flight;
  // the output register holds the finished item. Stage 1 moves on whenever the
  // output register is empty or is being taken, and an item is accepted only
  // when stage 1 can make room. While stage 1 waits no read is issued, so the
  // RAM read data stays put.
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r;
  logic out_free;
  logic in_accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Parser state.
  // ---------------------------------------------------------------------------
  rle8_pkg::phase_t          phase_r, phase_nxt;
  logic [7:0]                held_count_r, held_count_nxt;
  logic [7:0]                literal_left_r, literal_left_nxt;
  logic                      pad_due_r, pad_due_nxt;
  logic [COORD_BITS-1:0]     cursor_x_r, cursor_x_nxt;
  logic [YW-1:0]             cursor_y_r, cursor_y_nxt;
  logic                      frame_done_r, frame_done_nxt;

  logic                      is_stream;
  logic [7:0]                b;

  assign b         = in_stream_byte;
  assign is_stream = in_accept && (in_req_type == rle8_pkg::REQ_STREAM_BYTE) && !frame_done_r;

  // Next phase of the byte parser.
  always_comb begin
    phase_nxt = phase_r;
    if (in_accept && (in_req_type == rle8_pkg::REQ_FRAME_START)) begin
      phase_nxt = rle8_pkg::PH_COUNT;
    end else if (is_stream) begin
      unique case (phase_r)
        rle8_pkg::PH_COUNT: begin
          phase_nxt = (b != 8'd0) ? rle8_pkg::PH_INDEX : rle8_pkg::PH_ESCAPE;
        end
        rle8_pkg::PH_ESCAPE: begin
          priority if (b == rle8_pkg::ESC_END_OF_LINE || b == rle8_pkg::ESC_END_OF_BITMAP) begin
            phase_nxt = rle8_pkg::PH_COUNT;
          end else if (b == rle8_pkg::ESC_DELTA) begin
            phase_nxt = rle8_pkg::PH_DX;
          end else begin
            phase_nxt = rle8_pkg::PH_LITERAL;
          end
        end
        rle8_pkg::PH_DX: phase_nxt = rle8_pkg::PH_DY;
        rle8_pkg::PH_LITERAL: begin
          if (literal_left_r == 8'd1) begin
            phase_nxt = pad_due_r ? rle8_pkg::PH_PAD : rle8_pkg::PH_COUNT;
          end
        end
        default: phase_nxt = rle8_pkg::PH_COUNT;
      endcase
    end
  end

  // Cursor arithmetic. One saturating add serves runs, literal pixels and delta
  // moves, one subtract serves end of line and delta moves.
  logic [7:0]            add_n;
  logic [7:0]            sub_n;
  logic [COORD_BITS:0]   x_sum;
  logic [COORD_BITS-1:0] x_adv;
  logic [YW-1:0]         y_low;
  logic                  is_run;
  logic [7:0]            run_len;

  always_comb begin
    unique case (phase_r)
      rle8_pkg::PH_INDEX: add_n = held_count_r;
      rle8_pkg::PH_DX:    add_n = b;
      default:            add_n = 8'd1;
    endcase
    sub_n = (phase_r == rle8_pkg::PH_DY) ? b : 8'd1;
    x_sum = {1'b0, cursor_x_r} + (COORD_BITS + 1)'(add_n);
    x_adv = x_sum[COORD_BITS] ? COORD_MAX : x_sum[COORD_BITS-1:0];
    // Once the row has gone above the top it stays pinned at all ones.
    if (cursor_y_r[COORD_BITS]) begin
      y_low = cursor_y_r;
    end else if (cursor_y_r < YW'(sub_n)) begin
      y_low = {YW{1'b1}};
    end else begin
      y_low = cursor_y_r - YW'(sub_n);
    end
  end

  // Start row for a frame start item.
  logic [YW-1:0]             start_row;
  logic [rle8_pkg::DIM_W:0]  height_m1;

  always_comb begin
    height_m1 = {1'b0, image_height_r} - (rle8_pkg::DIM_W + 1)'(1);
    if (image_height_r == '0) begin
      start_row = {YW{1'b1}};
    end else if (height_m1 > (rle8_pkg::DIM_W + 1)'(COORD_MAX)) begin
      start_row = {1'b0, COORD_MAX};
    end else begin
      start_row = YW'(height_m1);
    end
  end

  // Parser datapath and run emission.
  logic emit_fe;
  always_comb begin
    held_count_nxt   = held_count_r;
    literal_left_nxt = literal_left_r;
    pad_due_nxt      = pad_due_r;
    cursor_x_nxt     = cursor_x_r;
    cursor_y_nxt     = cursor_y_r;
    frame_done_nxt   = frame_done_r;
    is_run           = 1'b0;
    emit_fe          = 1'b0;
    run_len          = held_count_r;
    if (in_accept && (in_req_type == rle8_pkg::REQ_FRAME_START)) begin
      held_count_nxt   = 8'd0;
      literal_left_nxt = 8'd0;
      pad_due_nxt      = 1'b0;
      frame_done_nxt   = 1'b0;
      cursor_x_nxt     = '0;
      cursor_y_nxt     = start_row;
    end else if (is_stream) begin
      unique case (phase_r)
        rle8_pkg::PH_COUNT: begin
          if (b != 8'd0) begin
            held_count_nxt = b;
          end
        end
        rle8_pkg::PH_INDEX: begin
          is_run       = 1'b1;
          run_len      = held_count_r;
          cursor_x_nxt = x_adv;
        end
        rle8_pkg::PH_ESCAPE: begin
          priority if (b == rle8_pkg::ESC_END_OF_LINE) begin
            cursor_x_nxt = '0;
            cursor_y_nxt = y_low;
          end else if (b == rle8_pkg::ESC_END_OF_BITMAP) begin
            frame_done_nxt = 1'b1;
            emit_fe        = 1'b1;
          end else if (b == rle8_pkg::ESC_DELTA) begin
            cursor_x_nxt = cursor_x_r;
          end else begin
            literal_left_nxt = b;
            pad_due_nxt      = b[0];
          end
        end
        rle8_pkg::PH_DX: cursor_x_nxt = x_adv;
        rle8_pkg::PH_DY: cursor_y_nxt = y_low;
        rle8_pkg::PH_LITERAL: begin
          is_run           = 1'b1;
          run_len          = 8'd1;
          cursor_x_nxt     = x_adv;
          literal_left_nxt = literal_left_r - 8'd1;
        end
        default: pad_due_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= rle8_pkg::PH_COUNT;
      held_count_r   <= 8'd0;
      literal_left_r <= 8'd0;
      pad_due_r      <= 1'b0;
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      frame_done_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      held_count_r   <= held_count_nxt;
      literal_left_r <= literal_left_nxt;
      pad_due_r      <= pad_due_nxt;
      cursor_x_r     <= cursor_x_nxt;
      cursor_y_r     <= cursor_y_nxt;
      frame_done_r   <= frame_done_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Palette store: a RAM plus one valid bit per entry. An entry that was never
  // written since reset reads as zero. Indexes past the palette size are
  // dropped on write and read as zero.
  // ---------------------------------------------------------------------------
  logic                pal_we;
  logic                idx_ok_wr, idx_ok_rd;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [rle8_pkg::COLOR_W-1:0] pal_q;
  logic [PALETTE_ENTRIES-1:0]   pal_valid_r;

  assign idx_ok_wr = 32'(in_palette_index) < PALETTE_ENTRIES;
  assign idx_ok_rd = 32'(b) < PALETTE_ENTRIES;
  assign wr_addr   = in_palette_index[AW-1:0];
  assign rd_addr   = b[AW-1:0];
  assign pal_we    = in_accept && (in_req_type == rle8_pkg::REQ_PALETTE_WR) && idx_ok_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_valid_r <= '0;
    end else if (pal_we) begin
      pal_valid_r[wr_addr] <= 1'b1;
    end
  end

  rle8_ram #(
    .WIDTH (rle8_pkg::COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (wr_addr),
    .wdata ({in_palette_red, in_palette_green, in_palette_blue}),
    .re    (is_run),
    .raddr (rd_addr),
    .rdata (pal_q)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: run geometry and edge flag, waiting for the palette data.
  // ---------------------------------------------------------------------------
  logic [rle8_pkg::OUT_COORD_W-1:0] s1_x_r, s1_y_r;
  logic [7:0]                       s1_len_r;
  logic                             s1_fe_r;
  logic                             s1_out_r;
  logic                             s1_hit_r;
  logic [CMP_W-1:0]                 y_ext;
  logic [CMP_W-1:0]                 x_end;
  logic                             run_off;

  always_comb begin
    y_ext   = CMP_W'(cursor_y_r);
    x_end   = CMP_W'(cursor_x_r) + CMP_W'(run_len);
    run_off = cursor_y_r[COORD_BITS]
              || (y_ext >= CMP_W'(image_height_r))
              || (x_end > CMP_W'(image_width_r));
  end

  assign s1_valid_nxt = is_run || emit_fe || (s1_valid_r && !out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_run || emit_fe) begin
      s1_x_r   <= is_run ? rle8_pkg::OUT_COORD_W'(cursor_x_r) : '0;
      s1_y_r   <= is_run ? y_ext[rle8_pkg::OUT_COORD_W-1:0] : '0;
      s1_len_r <= is_run ? run_len : 8'd0;
      s1_fe_r  <= emit_fe;
      s1_out_r <= is_run && run_off;
      s1_hit_r <= idx_ok_rd && pal_valid_r[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic [31:0] s1_color;
  assign s1_color = s1_fe_r ? 32'd0
                  : {rle8_pkg::ALPHA_OPAQUE,
                     (s1_hit_r ? pal_q : {rle8_pkg::COLOR_W{1'b0}})};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_run_x      <= s1_x_r;
      out_run_y      <= s1_y_r;
      out_run_length <= s1_len_r;
      out_run_color  <= s1_color;
      out_frame_end  <= s1_fe_r;
      out_outside    <= s1_out_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `RLE8_ASSERT_NEXT(a_done_blocks_runs,
    in_accept && (in_req_type == rle8_pkg::REQ_STREAM_BYTE) && frame_done_r
      && !(s1_valid_r && !out_free),
    !s1_valid_r, "stream item after end of bitmap produced a result")
  `RLE8_ASSERT_IMP(a_frame_end_clean, out_valid_r && out_frame_end,
    (out_run_length == 8'd0) && (out_run_color == 32'd0) && !out_outside,
    "frame end item carries run data")
  `RLE8_ASSERT_IMP(a_row_pinned, cursor_y_r[COORD_BITS], &cursor_y_r,
    "row above top is not pinned at all ones")

endmodule
